[sv/fixed_point_alu_defines.svh]
// ----------------------------------------------------------------------------
// fixed_point_alu_defines
// Assertion macros shared by the checker of the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Clocked assertion that is disabled while the reset is asserted.
`define FPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants of the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned QUO_BITS  = 33;

  localparam logic [63:0] ROUND_HALF =
    (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 neg;
    logic                 ovf;
    logic [31:0]          value;
    logic                 cmp;
    logic                 dz;
    logic                 sat;
    logic [63:0]          wide;
    logic [63:0]          dk;
    logic [QUO_BITS-1:0]  quo;
  } stage_t;

endpackage

[sv/fpa_front.sv]
// ----------------------------------------------------------------------------
// fpa_front
// Input stage: decodes the operation, finishes the simple operations and
// prepares the product or the division operands for the cell row.
// ----------------------------------------------------------------------------
module fpa_front
  import fpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         operation_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               stage_valid_o,
  output stage_t             stage_o,
  input  logic               next_ready_i
);

  logic               valid_q;
  stage_t             stage_q;
  stage_t             stage_d;
  logic signed [32:0] a_ext;
  logic signed [32:0] b_ext;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [63:0]        num;

  function automatic logic [32:0] clamp33(input logic signed [32:0] x);
    logic [32:0] r;
    if (x[32] != x[31]) begin
      r = {1'b1, (x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  assign a_ext = {operand_a_i[31], operand_a_i};
  assign b_ext = {operand_b_i[31], operand_b_i};
  assign mag_a = operand_a_i[31] ? (32'd0 - operand_a_i) : operand_a_i;
  assign mag_b = operand_b_i[31] ? (32'd0 - operand_b_i) : operand_b_i;
  assign num   = {32'd0, mag_a} << (FRAC_BITS + 1);

  always_comb begin
    stage_d       = '0;
    stage_d.kind  = KIND_DIRECT;
    stage_d.neg   = operand_a_i[31] ^ operand_b_i[31];
    stage_d.wide  = num;
    stage_d.dk    = {32'd0, mag_b} << (QUO_BITS - 1);
    stage_d.ovf   = {1'b0, num} >= ({33'd0, mag_b} << QUO_BITS);
    case (op_e'(operation_i))
      OP_ADD: {stage_d.sat, stage_d.value} = clamp33(a_ext + b_ext);
      OP_SUB: {stage_d.sat, stage_d.value} = clamp33(a_ext - b_ext);
      OP_INC: {stage_d.sat, stage_d.value} = clamp33(a_ext + 33'sd1);
      OP_DEC: {stage_d.sat, stage_d.value} = clamp33(a_ext - 33'sd1);
      OP_MUL: begin
        stage_d.kind = KIND_MUL;
        stage_d.wide = {32'd0, mag_a} * {32'd0, mag_b};
      end
      OP_DIV: begin
        if (operand_b_i == 32'sd0) begin
          stage_d.dz    = 1'b1;
          stage_d.value = operand_a_i;
        end else begin
          stage_d.kind = KIND_DIV;
        end
      end
      OP_GT:  stage_d.cmp = operand_a_i >  operand_b_i;
      OP_LT:  stage_d.cmp = operand_a_i <  operand_b_i;
      OP_GE:  stage_d.cmp = operand_a_i >= operand_b_i;
      OP_LE:  stage_d.cmp = operand_a_i <= operand_b_i;
      OP_EQ:  stage_d.cmp = operand_a_i == operand_b_i;
      OP_NE:  stage_d.cmp = operand_a_i != operand_b_i;
      OP_MIN: stage_d.value = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      OP_MAX: stage_d.value = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      default: stage_d.value = 32'd0;
    endcase
  end

  assign in_ready_o = !valid_q || next_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

[sv/fpa_div_cell.sv]
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring division step: compares the partial remainder with the
// shifted divisor, subtracts on success and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module fpa_div_cell
  import fpa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  stage_t stage_i,
  output logic   out_valid_o,
  output stage_t stage_o,
  input  logic   out_ready_i
);

  logic        valid_q;
  stage_t      stage_q;
  stage_t      stage_d;
  logic [64:0] diff;
  logic        take;

  assign diff = {1'b0, stage_i.wide} - {1'b0, stage_i.dk};
  assign take = !diff[64];

  always_comb begin
    stage_d = stage_i;
    if (stage_i.kind == KIND_DIV) begin
      stage_d.wide = take ? diff[63:0] : stage_i.wide;
      stage_d.quo  = {stage_i.quo[QUO_BITS-2:0], take};
      stage_d.dk   = stage_i.dk >> 1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = valid_q;
  assign stage_o     = stage_q;

endmodule

[sv/fpa_back.sv]
// ----------------------------------------------------------------------------
// fpa_back
// Output stage: rounds the product or the quotient, applies the sign,
// saturates and holds the result until it is taken.
// ----------------------------------------------------------------------------
module fpa_back
  import fpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stage_t             stage_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               compare_true_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  logic        valid_q;
  logic [31:0] value_q;
  logic [31:0] value_d;
  logic        cmp_q;
  logic        dz_q;
  logic        sat_q;
  logic        sat_d;
  logic [63:0] mul_mag;
  logic [63:0] div_mag;

  function automatic logic [32:0] clamp_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - mag[31:0]};
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, mag[31:0]};
      end
    end
    return r;
  endfunction

  assign mul_mag = (stage_i.wide + ROUND_HALF) >> FRAC_BITS;
  assign div_mag = ({{(64 - QUO_BITS){1'b0}}, stage_i.quo} + 64'd1) >> 1;

  always_comb begin
    value_d = stage_i.value;
    sat_d   = stage_i.sat;
    case (stage_i.kind)
      KIND_MUL: {sat_d, value_d} = clamp_mag(stage_i.neg, mul_mag);
      KIND_DIV: begin
        if (stage_i.ovf) begin
          sat_d   = 1'b1;
          value_d = stage_i.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          {sat_d, value_d} = clamp_mag(stage_i.neg, div_mag);
        end
      end
      default: begin
        value_d = stage_i.value;
        sat_d   = stage_i.sat;
      end
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      value_q <= value_d;
      cmp_q   <= stage_i.cmp;
      dz_q    <= stage_i.dz;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign result_value_o   = value_q;
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;
  assign saturated_o      = sat_q;

endmodule

[sv/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU with rounding and saturation.
// ----------------------------------------------------------------------------
// The ALU accepts one transfer per cycle while no output stall holds it and
// returns the results in order, for every operation, through an input stage,
// a row of 33 restoring division cells that produce one quotient bit each, and
// an output register. A stall on the output side fills the free stages
// before the input side is held.
module fixed_point_alu
  import fpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         operation_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               compare_true_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  stage_t stage   [QUO_BITS+1];
  logic   stg_vld [QUO_BITS+1];
  logic   stg_rdy [QUO_BITS+1];

  fpa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .stage_valid_o (stg_vld[0]),
    .stage_o       (stage[0]),
    .next_ready_i  (stg_rdy[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_vld[i]),
      .in_ready_o  (stg_rdy[i]),
      .stage_i     (stage[i]),
      .out_valid_o (stg_vld[i+1]),
      .stage_o     (stage[i+1]),
      .out_ready_i (stg_rdy[i+1])
    );
  end

  fpa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (stg_vld[QUO_BITS]),
    .in_ready_o       (stg_rdy[QUO_BITS]),
    .stage_i          (stage[QUO_BITS]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o),
    .compare_true_o   (compare_true_o),
    .divide_by_zero_o (divide_by_zero_o),
    .saturated_o      (saturated_o)
  );

endmodule

[sv/fpa_checker.sv]
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_defines.svh"

module fpa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] result_value_o,
  input logic               compare_true_o,
  input logic               divide_by_zero_o,
  input logic               saturated_o
);

  `FPA_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> out_valid_o,
              "Result dropped before its transfer.")
  `FPA_ASSERT(a_out_stable, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> $stable(result_value_o) && $stable(saturated_o),
              "Stalled result changed.")
  `FPA_ASSERT(a_cmp_clean, clk_i, rst_ni,
              out_valid_o && compare_true_o |->
                result_value_o == 32'sd0 && !divide_by_zero_o && !saturated_o,
              "Comparison result carries other fields.")
  `FPA_ASSERT(a_dz_clean, clk_i, rst_ni,
              out_valid_o && divide_by_zero_o |-> !saturated_o && !compare_true_o,
              "Zero divisor result also saturated.")
  `FPA_ASSERT_ALWAYS(a_sat_bound, clk_i,
                     !rst_ni || !(out_valid_o && saturated_o) ||
                       result_value_o == 32'sh7FFF_FFFF || result_value_o == 32'sh8000_0000,
                     "Saturated result is not a range limit.")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined fixed-point ALU. A short directed
// set covers operand extremes, every opcode, saturation, rounding, the zero
// divisor and the unused opcodes. About 1500 random transfers follow. Input
// transfers come in bursts with random gaps, and the output side stalls on
// its own pattern, with one long hold-off that fills the pipeline. Every
// result is checked field by field against a bit-exact prediction.
// ----------------------------------------------------------------------------
module testbench
  import fpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] MAX_RAW      = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_RAW      = 32'sh80000000;
  localparam logic [3:0]         OP_UNUSED_LO = 4'd14;
  localparam logic [3:0]         OP_UNUSED_HI = 4'd15;
  localparam int unsigned        RANDOM_ITEMS = 1500;
  localparam int unsigned        HOLD_AFTER   = 400;
  localparam int unsigned        HOLD_CYCLES  = 400;
  localparam int unsigned        DRAIN_CYCLES = 40;
  localparam int unsigned        CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
    logic               sat;
  } alu_result_t;

  function automatic alu_result_t clamp_wide(longint x);
    alu_result_t r;
    r = '0;
    if (x > longint'(MAX_RAW)) begin
      r.value = MAX_RAW;
      r.sat   = 1'b1;
    end else if (x < longint'(MIN_RAW)) begin
      r.value = MIN_RAW;
      r.sat   = 1'b1;
    end else begin
      r.value = x[31:0];
    end
    return r;
  endfunction

  function automatic alu_result_t clamp_magnitude(bit neg, longint unsigned mag);
    alu_result_t    r;
    longint unsigned twos;
    r = '0;
    if (neg) begin
      if (mag > 64'd2147483648) begin
        r.value = MIN_RAW;
        r.sat   = 1'b1;
      end else begin
        twos    = 64'd0 - mag;
        r.value = twos[31:0];
      end
    end else if (mag > 64'd2147483647) begin
      r.value = MAX_RAW;
      r.sat   = 1'b1;
    end else begin
      r.value = mag[31:0];
    end
    return r;
  endfunction

  function automatic alu_result_t fixed_point_eval(logic [3:0] op, logic signed [31:0] a,
                                                   logic signed [31:0] b);
    alu_result_t     r;
    longint          sa;
    longint          sb;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned half;
    longint unsigned mag;
    longint unsigned num;
    bit              neg;
    r    = '0;
    sa   = a;
    sb   = b;
    ma   = (sa < 0) ? longint'(-sa) : sa;
    mb   = (sb < 0) ? longint'(-sb) : sb;
    neg  = (sa < 0) != (sb < 0);
    half = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
    case (op)
      OP_ADD: r = clamp_wide(sa + sb);
      OP_SUB: r = clamp_wide(sa - sb);
      OP_MUL: begin
        mag = (ma * mb + half) >> FRAC_BITS;
        if (mag == 0) neg = 1'b0;
        r = clamp_magnitude(neg, mag);
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.value = a;
          r.dz    = 1'b1;
        end else begin
          num = ma << FRAC_BITS;
          mag = (2 * num + mb) / (2 * mb);
          if (mag == 0) neg = 1'b0;
          r = clamp_magnitude(neg, mag);
        end
      end
      OP_GT:  r.cmp = sa > sb;
      OP_LT:  r.cmp = sa < sb;
      OP_GE:  r.cmp = sa >= sb;
      OP_LE:  r.cmp = sa <= sb;
      OP_EQ:  r.cmp = sa == sb;
      OP_NE:  r.cmp = sa != sb;
      OP_MIN: r.value = (sa < sb) ? a : b;
      OP_MAX: r.value = (sa > sb) ? a : b;
      OP_INC: r = clamp_wide(sa + 1);
      OP_DEC: r = clamp_wide(sa - 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  class result_tracker;
    alu_result_t pending_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_operation(logic [3:0] op, logic signed [31:0] a,
                                 logic signed [31:0] b);
      pending_results.push_back(fixed_point_eval(op, a, b));
    endfunction

    function void compare_field(string field, logic signed [31:0] expected_v,
                                logic signed [31:0] actual_v);
      if (actual_v !== expected_v) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, expected_v, actual_v);
      end
    endfunction

    function void check_result(alu_result_t actual);
      alu_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %0d", $time, actual.value);
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("result_value", exp_r.value, actual.value);
      compare_field("compare_true", 32'(exp_r.cmp), 32'(actual.cmp));
      compare_field("divide_by_zero", 32'(exp_r.dz), 32'(actual.dz));
      compare_field("saturated", 32'(exp_r.sat), 32'(actual.sat));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [3:0]         operation_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic               compare_true_o;
  logic               divide_by_zero_o;
  logic               saturated_o;

  result_tracker tracker = new();
  int unsigned   accepted_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycle_count = 0;

  fixed_point_alu dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .compare_true_o  (compare_true_o),
    .divide_by_zero_o(divide_by_zero_o),
    .saturated_o     (saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      tracker.note_operation(operation_i, operand_a_i, operand_b_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({result_value_o, compare_true_o, divide_by_zero_o, saturated_o});
    end
  end

  task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    accepted_count++;
  endtask

  task automatic issue(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6:    gap = $urandom_range(1, 3);
        7, 8:       gap = $urandom_range(4, 15);
        default:    gap = $urandom_range(16, 60);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    send_item(op, a, b);
  endtask

  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3:       v = int'($urandom_range(0, 4095)) - 2048;
      4: begin
        case ($urandom_range(0, 8))
          0:       v = MAX_RAW;
          1:       v = MIN_RAW;
          2:       v = 0;
          3:       v = 1;
          4:       v = -1;
          5:       v = MAX_RAW - 1;
          6:       v = MIN_RAW + 1;
          7:       v = 1 <<< FRAC_BITS;
          default: v = -(1 <<< FRAC_BITS);
        endcase
      end
      5:       v = (int'($urandom_range(0, 511)) - 256) <<< FRAC_BITS;
      6:       v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin : receiver
    bit          hold_done;
    int unsigned mode;
    int unsigned len;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 150);
      repeat (len) begin
        if (!hold_done && accepted_count >= HOLD_AFTER) begin
          hold_done = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= $urandom_range(0, 1);
            2:       out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_ADD, MAX_RAW, 1);
    issue(OP_ADD, MIN_RAW, -1);
    issue(OP_ADD, 32'sh00000180, -32'sh00000080);
    issue(OP_SUB, MIN_RAW, 1);
    issue(OP_SUB, MAX_RAW, -1);
    issue(OP_MUL, MAX_RAW, MAX_RAW);
    issue(OP_MUL, MIN_RAW, MAX_RAW);
    issue(OP_MUL, MIN_RAW, MIN_RAW);
    issue(OP_MUL, 1, 128);
    issue(OP_MUL, -1, 128);
    issue(OP_MUL, 1, 127);
    issue(OP_DIV, MIN_RAW, 0);
    issue(OP_DIV, MIN_RAW, 1);
    issue(OP_DIV, MAX_RAW, MIN_RAW);
    issue(OP_DIV, 1, 3);
    issue(OP_DIV, -1, 1024);
    issue(OP_GT, MAX_RAW, MIN_RAW);
    issue(OP_LT, MAX_RAW, MIN_RAW);
    issue(OP_GE, MIN_RAW, MIN_RAW);
    issue(OP_LE, MAX_RAW, MAX_RAW);
    issue(OP_EQ, MIN_RAW, MIN_RAW);
    issue(OP_NE, MIN_RAW, MAX_RAW);
    issue(OP_MIN, MIN_RAW, MAX_RAW);
    issue(OP_MAX, MIN_RAW, MAX_RAW);
    issue(OP_INC, MAX_RAW, MIN_RAW);
    issue(OP_DEC, MIN_RAW, MAX_RAW);
    issue(OP_UNUSED_LO, MAX_RAW, MAX_RAW);
    issue(OP_UNUSED_HI, MIN_RAW, -1);

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 2) begin
        op = ($urandom_range(0, 1) == 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end else begin
        op = 4'($urandom_range(OP_ADD, OP_DEC));
      end
      a = pick_operand();
      b = pick_operand();
      if ($urandom_range(0, 9) == 0) b = a;
      if (op == OP_DIV && $urandom_range(0, 9) == 0) b = 0;
      issue(op, a, b);
    end
    in_valid_i <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
